[design/fbpr_pkg.sv]
// ---------------------------------------------------------------------------
// fbpr_pkg - shared definitions for the frame buffer page refresh block
// Item kinds, controller command bytes, refresh phases and default geometry.
// ---------------------------------------------------------------------------
package fbpr_pkg;

    // Default screen geometry
    localparam int DEF_WIDTH  = 84;
    localparam int DEF_HEIGHT = 48;

    // Item kinds
    localparam logic [1:0] KIND_TRACKED   = 2'd0;
    localparam logic [1:0] KIND_UNTRACKED = 2'd1;
    localparam logic [1:0] KIND_CLEAR     = 2'd2;
    localparam logic [1:0] KIND_REFRESH   = 2'd3;

    // Controller command bytes
    localparam logic [7:0] CMD_SET_PAGE = 8'h40;
    localparam logic [7:0] CMD_SET_COL  = 8'h80;

    // Refresh phase within one page
    typedef enum logic [1:0] {
        PH_PAGE = 2'd0,
        PH_COL  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

endpackage

[design/framebuffer_page_refresh.sv]
// ---------------------------------------------------------------------------
// framebuffer_page_refresh - 1-bit paged frame store with dirty-box refresh
// Keeps the picture in a synchronous memory of 8-row pages, tracks a dirty
// box and streams the box to a display controller one byte per refresh item.
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  item in  | start & !busy         | i_kind, i_x, i_y, i_color
//  result   | o_strobe (one cycle)  | o_byte_res, o_is_data, o_last,
//           |                       | o_empty_res
//
//  Pixel write: memory read, then modify and write back.
//  Out-of-range write: no effect. Refresh command byte: registered from the item.
//  Refresh data byte: a synchronous memory read, then presented from S_DATA.
//  Clear item and reset: a sweep over all WIDTH*ceil(HEIGHT/8) store bytes (504 by
//  default), one store byte zeroed per cycle, busy high throughout.
//  Results are shown for one cycle; the receiver cannot stall them.
// ---------------------------------------------------------------------------
module framebuffer_page_refresh #(
    parameter int WIDTH  = fbpr_pkg::DEF_WIDTH,
    parameter int HEIGHT = fbpr_pkg::DEF_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_x,
    input  logic [7:0] i_y,
    input  logic       i_color,
    output logic       o_strobe,
    output logic [7:0] o_byte_res,
    output logic       o_is_data,
    output logic       o_last,
    output logic       o_empty_res
);

    localparam int PAGES  = (HEIGHT + 7) / 8;
    localparam int DEPTH  = WIDTH * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RMW   = 4'b0100,
        S_DATA  = 4'b1000
    } t_state;

    // Frame store
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr_cnt, n_clr_cnt;

    // Pending pixel write
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic [2:0]        r_bit, n_bit;
    logic              r_color, n_color;

    // Live box
    logic [6:0] r_min_x, n_min_x, r_max_x, n_max_x;
    logic [5:0] r_min_y, n_min_y, r_max_y, n_max_y;

    // Latched box and refresh progress
    logic [6:0]        r_lb_min_x, n_lb_min_x, r_lb_max_x, n_lb_max_x;
    logic [5:0]        r_lb_min_y, n_lb_min_y, r_lb_max_y, n_lb_max_y;
    logic              r_active, n_active;
    logic [2:0]        r_page, n_page;
    logic [6:0]        r_col, n_col;
    fbpr_pkg::t_phase  r_phase, n_phase;

    // Data byte flags held over the memory read
    logic r_pend_last, n_pend_last;

    // Result register
    logic       r_strobe, n_strobe;
    logic [7:0] r_byte, n_byte;
    logic       r_is_data, n_is_data, r_last, n_last, r_empty, n_empty;

    // Memory port controls
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    logic accept;
    logic in_range;
    logic [ADDR_W-1:0] pix_addr;

    // First selected page at or after start: {found, page}
    function automatic logic [3:0] f_next_page(input logic [3:0] pg_start,
                                               input logic [5:0] min_y,
                                               input logic [5:0] max_y);
        logic [6:0] ceil_pg;
        logic [3:0] first;
        logic [3:0] pick;
        logic       found;
        ceil_pg = ({1'b0, min_y} + 7'd7) >> 3;
        first   = (ceil_pg == 7'd0) ? 4'd0 : 4'(ceil_pg - 7'd1);
        pick    = (pg_start > first) ? pg_start : first;
        found   = (pick < 4'(PAGES)) && ({pick[3:0], 3'b000} <= {1'b0, max_y});
        return {found, pick[2:0]};
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign in_range = (i_x < 8'(WIDTH)) && (i_y < 8'(HEIGHT));
    assign pix_addr = ADDR_W'(ADDR_W'(i_y[5:3]) * ADDR_W'(WIDTH) + ADDR_W'(i_x[6:0]));

    // Next-state logic for control, box and refresh progress
    always_comb begin
        logic [3:0]       np;
        logic             act;
        logic [2:0]       e_page;
        logic [6:0]       e_col;
        fbpr_pkg::t_phase e_phase;
        logic             adv;
        logic             fin;

        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_wr_addr   = r_wr_addr;
        n_bit       = r_bit;
        n_color     = r_color;
        n_min_x     = r_min_x;
        n_min_y     = r_min_y;
        n_max_x     = r_max_x;
        n_max_y     = r_max_y;
        n_lb_min_x  = r_lb_min_x;
        n_lb_min_y  = r_lb_min_y;
        n_lb_max_x  = r_lb_max_x;
        n_lb_max_y  = r_lb_max_y;
        n_active    = r_active;
        n_page      = r_page;
        n_col       = r_col;
        n_phase     = r_phase;
        n_pend_last = r_pend_last;
        n_strobe    = 1'b0;
        n_byte      = r_byte;
        n_is_data   = r_is_data;
        n_last      = r_last;
        n_empty     = r_empty;
        rd_en       = 1'b0;
        rd_addr     = pix_addr;
        wr_en       = 1'b0;
        wr_addr     = r_wr_addr;
        wr_data     = r_rd_data;
        np          = '0;
        act         = r_active;
        e_page      = r_page;
        e_col       = r_col;
        e_phase     = r_phase;
        adv         = 1'b0;
        fin         = 1'b0;

        unique case (r_state)
            // Zero the store one byte per cycle
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_cnt;
                wr_data = 8'h00;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // Write back the modified byte
            S_RMW: begin
                wr_en   = 1'b1;
                wr_addr = r_wr_addr;
                wr_data = r_rd_data;
                wr_data[r_bit] = r_color;
                n_state = S_IDLE;
            end

            // Present the data byte read last cycle
            S_DATA: begin
                n_strobe  = 1'b1;
                n_byte    = r_rd_data;
                n_is_data = 1'b1;
                n_last    = r_pend_last;
                n_empty   = 1'b0;
                n_state   = S_IDLE;
            end

            S_IDLE: begin
                if (accept) begin
                    unique case (i_kind) inside
                        fbpr_pkg::KIND_TRACKED, fbpr_pkg::KIND_UNTRACKED: begin
                            if (in_range) begin
                                rd_en     = 1'b1;
                                rd_addr   = pix_addr;
                                n_wr_addr = pix_addr;
                                n_bit     = i_y[2:0];
                                n_color   = i_color;
                                n_state   = S_RMW;
                                if (i_kind == fbpr_pkg::KIND_TRACKED) begin
                                    if (i_x[6:0] < r_min_x) n_min_x = i_x[6:0];
                                    if (i_y[5:0] < r_min_y) n_min_y = i_y[5:0];
                                    if (i_x[6:0] > r_max_x) n_max_x = i_x[6:0];
                                    if (i_y[5:0] > r_max_y) n_max_y = i_y[5:0];
                                end
                            end
                        end

                        fbpr_pkg::KIND_CLEAR: begin
                            n_min_x   = '0;
                            n_min_y   = '0;
                            n_max_x   = '0;
                            n_max_y   = '0;
                            n_clr_cnt = '0;
                            n_state   = S_CLEAR;
                        end

                        default: begin
                            // Latch the box at the start of a refresh
                            if (!r_active) begin
                                n_lb_min_x = r_min_x;
                                n_lb_min_y = r_min_y;
                                n_lb_max_x = r_max_x;
                                n_lb_max_y = r_max_y;
                                np = f_next_page(4'd0, r_min_y, r_max_y);
                                if (!np[3]) begin
                                    fin = 1'b1;
                                    n_strobe  = 1'b1;
                                    n_byte    = 8'h00;
                                    n_is_data = 1'b0;
                                    n_last    = 1'b1;
                                    n_empty   = 1'b1;
                                end else begin
                                    act     = 1'b1;
                                    e_page  = np[2:0];
                                    e_phase = fbpr_pkg::PH_PAGE;
                                    e_col   = '0;
                                end
                            end

                            if (act) begin
                                n_active  = 1'b1;
                                n_page    = e_page;
                                n_col     = e_col;
                                n_phase   = e_phase;
                                n_is_data = 1'b0;
                                n_last    = 1'b0;
                                n_empty   = 1'b0;
                                case (e_phase)
                                    fbpr_pkg::PH_PAGE: begin
                                        n_strobe = 1'b1;
                                        n_byte   = fbpr_pkg::CMD_SET_PAGE | {5'd0, e_page};
                                        n_phase  = fbpr_pkg::PH_COL;
                                    end
                                    fbpr_pkg::PH_COL: begin
                                        n_strobe = 1'b1;
                                        n_byte   = fbpr_pkg::CMD_SET_COL | {1'b0, n_lb_min_x};
                                        if (n_lb_min_x <= n_lb_max_x) begin
                                            n_phase = fbpr_pkg::PH_DATA;
                                            n_col   = n_lb_min_x;
                                        end else begin
                                            adv = 1'b1;
                                        end
                                    end
                                    default: begin
                                        rd_en   = 1'b1;
                                        rd_addr = ADDR_W'(ADDR_W'(e_page) * ADDR_W'(WIDTH)
                                                          + ADDR_W'(e_col));
                                        n_state = S_DATA;
                                        if (e_col < n_lb_max_x) begin
                                            n_col = e_col + 7'd1;
                                        end else begin
                                            adv = 1'b1;
                                        end
                                    end
                                endcase

                                // Move to the next selected page or finish
                                n_pend_last = 1'b0;
                                if (adv) begin
                                    np = f_next_page({1'b0, e_page} + 4'd1,
                                                     n_lb_min_y, n_lb_max_y);
                                    if (!np[3]) begin
                                        fin         = 1'b1;
                                        n_last      = 1'b1;
                                        n_pend_last = 1'b1;
                                        n_active    = 1'b0;
                                        n_phase     = fbpr_pkg::PH_PAGE;
                                        n_page      = '0;
                                        n_col       = '0;
                                    end else begin
                                        n_page  = np[2:0];
                                        n_phase = fbpr_pkg::PH_PAGE;
                                    end
                                end
                            end

                            // Widen the live box to the full screen
                            if (fin) begin
                                n_min_x = '0;
                                n_min_y = '0;
                                if (r_max_x < 7'(WIDTH - 1))  n_max_x = 7'(WIDTH - 1);
                                if (r_max_y < 6'(HEIGHT - 1)) n_max_y = 6'(HEIGHT - 1);
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    // Frame store ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_cnt  <= '0;
            r_min_x    <= '0;
            r_min_y    <= '0;
            r_max_x    <= '0;
            r_max_y    <= '0;
            r_lb_min_x <= '0;
            r_lb_min_y <= '0;
            r_lb_max_x <= '0;
            r_lb_max_y <= '0;
            r_active   <= 1'b0;
            r_page     <= '0;
            r_col      <= '0;
            r_phase    <= fbpr_pkg::PH_PAGE;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_cnt  <= n_clr_cnt;
            r_min_x    <= n_min_x;
            r_min_y    <= n_min_y;
            r_max_x    <= n_max_x;
            r_max_y    <= n_max_y;
            r_lb_min_x <= n_lb_min_x;
            r_lb_min_y <= n_lb_min_y;
            r_lb_max_x <= n_lb_max_x;
            r_lb_max_y <= n_lb_max_y;
            r_active   <= n_active;
            r_page     <= n_page;
            r_col      <= n_col;
            r_phase    <= n_phase;
            r_strobe   <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_wr_addr   <= n_wr_addr;
        r_bit       <= n_bit;
        r_color     <= n_color;
        r_pend_last <= n_pend_last;
        r_byte      <= n_byte;
        r_is_data   <= n_is_data;
        r_last      <= n_last;
        r_empty     <= n_empty;
    end

    assign o_strobe    = r_strobe;
    assign o_byte_res  = r_byte;
    assign o_is_data   = r_is_data;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;

endmodule

[design/fbpr_checker.sv]
// ---------------------------------------------------------------------------
// fbpr_checker - port-level checks for the frame buffer page refresh block
// Relates results to the refresh items that caused them.
// ---------------------------------------------------------------------------
module fbpr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_kind,
    input logic       o_strobe,
    input logic [7:0] o_byte_res,
    input logic       o_is_data,
    input logic       o_last,
    input logic       o_empty_res
);

    logic acc_refresh;
    assign acc_refresh = start && !busy && (i_kind == fbpr_pkg::KIND_REFRESH);

    // Command bytes come in the cycle after their refresh item
    a_cmd_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_is_data |-> $past(acc_refresh))
        else $error("command byte without a refresh item");

    // Data bytes follow their refresh item through the memory read and S_DATA
    a_data_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_is_data |-> $past(acc_refresh, 2))
        else $error("data byte without a refresh item");

    // An empty refresh is a single zero command that ends the refresh
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_empty_res |-> o_last && !o_is_data && (o_byte_res == 8'h00))
        else $error("malformed empty refresh result");

    // A clear item occupies the block
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_kind == fbpr_pkg::KIND_CLEAR) |=> busy)
        else $error("clear item did not start a sweep");

endmodule

bind framebuffer_page_refresh fbpr_checker u_fbpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_kind      (i_kind),
    .o_strobe    (o_strobe),
    .o_byte_res  (o_byte_res),
    .o_is_data   (o_is_data),
    .o_last      (o_last),
    .o_empty_res (o_empty_res)
);
